// File: hw/rtl/first_fit_range_allocator_assert.svh
// Assertion macros used by the checker file ffra_checker.sv.
`ifndef FIRST_FIT_RANGE_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_RANGE_ALLOCATOR_ASSERT_SVH
// implication checked every clock edge outside reset
`define FFRA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define FFRA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// File: hw/rtl/ffra_pkg.sv
`timescale 1ns / 1ps
package ffra_pkg;
   localparam int MAX_RANGES = 64;
   localparam int ADDR_BITS  = 40;
   localparam int LEN_BITS   = ADDR_BITS + 1;
   localparam int IDX_BITS   = $clog2(MAX_RANGES);
   localparam int CNT_BITS   = IDX_BITS + 1;
   localparam int PAGE_BITS  = 12;

   typedef logic [ADDR_BITS-1:0] addr_type;
   typedef logic [LEN_BITS-1:0]  len_type;
   typedef logic [IDX_BITS-1:0]  idx_type;
   typedef logic [CNT_BITS-1:0]  cnt_type;
   typedef logic [ADDR_BITS+LEN_BITS-1:0] entry_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_NOFIT = 2'd1,
      ST_UNDER = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   typedef enum logic [0:0] {
      FN_ALLOC = 1'b0,
      FN_FREE  = 1'b1
   } func_type;

   typedef enum logic [3:0] {
      S_IDLE, S_SCAN, S_SCANW, S_DECIDE, S_RDPOS, S_RDPOSW, S_MERGE,
      S_REMRD, S_REMWR, S_INSRD, S_INSWR, S_RESP
   } state_type;

   localparam len_type LEN_MAX = '1;

   function automatic len_type round_page(input len_type v);
      logic [LEN_BITS:0] r;
      if (v[PAGE_BITS-1:0] == '0) return v;
      r = {1'b0, v[LEN_BITS-1:PAGE_BITS], {PAGE_BITS{1'b0}}}
          + {{(LEN_BITS-PAGE_BITS){1'b0}}, 1'b1, {PAGE_BITS{1'b0}}};
      if (r[LEN_BITS]) return v;
      return r[LEN_BITS-1:0];
   endfunction

   function automatic len_type sat_add(input len_type a, input len_type b);
      logic [LEN_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[LEN_BITS] ? LEN_MAX : s[LEN_BITS-1:0];
   endfunction
endpackage

// File: hw/rtl/ffra_ram.sv
`timescale 1ns / 1ps
module ffra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

// File: hw/rtl/first_fit_range_allocator.sv
`timescale 1ns / 1ps
// First-fit range allocator.
// Input channel req_*: one transaction per operation (req_func 0 allocate,
// 1 free), size rounded up to 4 KiB pages. Result channel rsp_*: exactly one
// transaction per request, carrying status, allocated offset and bytes used.
// The free-range table (start, length) sits in one single-port-write RAM with
// a registered read; every operation but a zero-size free walks it entry by
// entry. An allocate scans entries until one fits and, on a removal, shifts
// the later entries down; a free scans to its insert point, passes through
// the merge state, then shifts the tail on insert or removal. A zero-size
// free goes straight to the result. One operation is in flight at a time;
// the next request is taken the cycle after the result is delivered.
// csr_wr_en/csr_wr_data load the pool size; the table becomes one range at 0,
// or empty for size 0, at once (range count register and entry 0 only, no sweep).
// Reset (synchronous, active high): pool size 0, table empty, used count 0.
// A stalled receiver (rsp_ready low) holds the result in the output register;
// no new request is taken until it is delivered.
module first_fit_range_allocator (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_func,
   input  ffra_pkg::len_type         req_bytes,
   input  ffra_pkg::addr_type        req_free_offset,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [1:0]                rsp_status,
   output ffra_pkg::addr_type        rsp_alloc_offset,
   output ffra_pkg::len_type         rsp_used_total,
   input  logic                      csr_wr_en,
   input  ffra_pkg::len_type         csr_wr_data
);
   import ffra_pkg::*;

   state_type  state_ff, state_in;
   cnt_type    count_ff, count_in;
   len_type    used_ff, used_in;
   cnt_type    idx_ff, idx_in;
   func_type   func_ff, func_in;
   len_type    sz_ff, sz_in;
   addr_type   off_ff, off_in;
   status_type st_ff, st_in;
   addr_type   aoff_ff, aoff_in;
   entry_type  left_ff, left_in;
   logic       has_left_ff, has_left_in;
   entry_type  hold_ff, hold_in;

   logic       wr_en;
   idx_type    wr_addr, rd_addr;
   entry_type  wr_data, rd_data;
   addr_type   rd_start;
   len_type    rd_len;

   ffra_ram #(.WIDTH(ADDR_BITS + LEN_BITS), .DEPTH(MAX_RANGES)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   assign rd_start = rd_data[ADDR_BITS+LEN_BITS-1:LEN_BITS];
   assign rd_len   = rd_data[LEN_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         used_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         used_ff  <= used_in;
      end
      idx_ff      <= idx_in;
      func_ff     <= func_in;
      sz_ff       <= sz_in;
      off_ff      <= off_in;
      st_ff       <= st_in;
      aoff_ff     <= aoff_in;
      left_ff     <= left_in;
      has_left_ff <= has_left_in;
      hold_ff     <= hold_in;
   end

   always_comb begin
      logic [LEN_BITS:0] lend;
      logic [LEN_BITS:0] rend;
      len_type           nlen;
      state_in    = state_ff;
      count_in    = count_ff;
      used_in     = used_ff;
      idx_in      = idx_ff;
      func_in     = func_ff;
      sz_in       = sz_ff;
      off_in      = off_ff;
      st_in       = st_ff;
      aoff_in     = aoff_ff;
      left_in     = left_ff;
      has_left_in = has_left_ff;
      hold_in     = hold_ff;
      wr_en       = 1'b0;
      wr_addr     = idx_ff[IDX_BITS-1:0];
      wr_data     = '0;
      rd_addr     = idx_ff[IDX_BITS-1:0];
      req_ready   = 1'b0;
      lend        = '0;
      rend        = '0;
      nlen        = '0;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               func_in = func_type'(req_func);
               sz_in   = round_page(req_bytes);
               off_in  = req_free_offset;
               aoff_in = '0;
               st_in   = ST_OK;
               idx_in  = '0;
               has_left_in = 1'b0;
               state_in = (func_type'(req_func) == FN_ALLOC) ? S_SCAN : S_RDPOS;
               if (func_type'(req_func) == FN_FREE) begin
                  if (used_ff >= round_page(req_bytes)) begin
                     used_in = used_ff - round_page(req_bytes);
                  end else begin
                     used_in = '0;
                     st_in   = ST_UNDER;
                  end
                  if (round_page(req_bytes) == '0) state_in = S_RESP;
               end
            end
         end
         // allocate: read entry idx
         S_SCAN: begin
            if (idx_ff >= count_ff) begin
               st_in    = ST_NOFIT;
               state_in = S_RESP;
            end else begin
               state_in = S_SCANW;
            end
         end
         S_SCANW: begin
            if (rd_len >= sz_ff) begin
               aoff_in = rd_start;
               nlen    = rd_len - sz_ff;
               used_in = sat_add(used_ff, sz_ff);
               if (nlen == '0) begin
                  count_in = count_ff - 1'b1;
                  state_in = S_REMRD;
               end else begin
                  wr_en    = 1'b1;
                  wr_data  = {rd_start + sz_ff[ADDR_BITS-1:0], nlen};
                  state_in = S_RESP;
               end
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_SCAN;
            end
         end
         // remove entry idx: copy idx+1 down until end (count already reduced)
         S_REMRD: begin
            if (idx_ff >= count_ff) begin
               state_in = S_RESP;
            end else begin
               rd_addr  = idx_type'(idx_ff + 1'b1);
               state_in = S_REMWR;
            end
         end
         S_REMWR: begin
            wr_en    = 1'b1;
            wr_data  = rd_data;
            idx_in   = idx_ff + 1'b1;
            state_in = S_REMRD;
         end
         // free: find first entry with start > off
         S_RDPOS: begin
            if (idx_ff >= count_ff) begin
               state_in = S_MERGE;
               hold_in  = '0;
            end else begin
               state_in = S_RDPOSW;
            end
         end
         S_RDPOSW: begin
            if (rd_start <= off_ff) begin
               left_in     = rd_data;
               has_left_in = 1'b1;
               idx_in      = idx_ff + 1'b1;
               state_in    = S_RDPOS;
            end else begin
               hold_in  = rd_data;
               state_in = S_MERGE;
            end
         end
         S_MERGE: begin
            // full-width ends: no wrap may fake an adjacency
            lend = {2'b0, left_ff[ADDR_BITS+LEN_BITS-1:LEN_BITS]}
                   + {1'b0, left_ff[LEN_BITS-1:0]};
            rend = {2'b0, off_ff} + {1'b0, sz_ff};
            if (has_left_ff && lend == {2'b0, off_ff}) begin
               wr_addr = idx_type'(idx_ff - 1'b1);
               wr_en   = 1'b1;
               if (idx_ff < count_ff &&
                   rend == {2'b0, hold_ff[ADDR_BITS+LEN_BITS-1:LEN_BITS]}) begin
                  nlen = sat_add(sat_add(left_ff[LEN_BITS-1:0], sz_ff),
                                 hold_ff[LEN_BITS-1:0]);
                  wr_data  = {left_ff[ADDR_BITS+LEN_BITS-1:LEN_BITS], nlen};
                  count_in = count_ff - 1'b1;
                  state_in = S_REMRD;
               end else begin
                  wr_data  = {left_ff[ADDR_BITS+LEN_BITS-1:LEN_BITS],
                              sat_add(left_ff[LEN_BITS-1:0], sz_ff)};
                  state_in = S_RESP;
               end
            end else if (idx_ff < count_ff &&
                         rend == {2'b0, hold_ff[ADDR_BITS+LEN_BITS-1:LEN_BITS]}) begin
               wr_en    = 1'b1;
               wr_data  = {off_ff, sat_add(sz_ff, hold_ff[LEN_BITS-1:0])};
               state_in = S_RESP;
            end else if (count_ff >= cnt_type'(MAX_RANGES)) begin
               st_in    = ST_FULL;
               state_in = S_RESP;
            end else begin
               // shift tail up from the top, then write new entry at idx
               hold_in  = {off_ff, sz_ff};
               count_in = count_ff + 1'b1;
               state_in = S_INSRD;
               left_in  = {off_ff, sz_ff};
               idx_in   = count_ff;
               off_in   = off_ff;
               aoff_in  = addr_type'(idx_ff);
            end
         end
         // insert: idx walks down from old count to pos (kept in aoff)
         S_INSRD: begin
            if (idx_ff == cnt_type'(aoff_ff[CNT_BITS-1:0])) begin
               wr_en    = 1'b1;
               wr_data  = left_ff;
               aoff_in  = '0;
               state_in = S_RESP;
            end else begin
               rd_addr  = idx_type'(idx_ff - 1'b1);
               state_in = S_INSWR;
            end
         end
         S_INSWR: begin
            wr_en    = 1'b1;
            wr_data  = rd_data;
            idx_in   = idx_ff - 1'b1;
            state_in = S_INSRD;
         end
         S_RESP: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase

      // pool load: to be done only while idle; the block itself does not enforce it
      if (csr_wr_en) begin
         wr_en    = 1'b1;
         wr_addr  = '0;
         wr_data  = {{ADDR_BITS{1'b0}}, csr_wr_data};
         count_in = (csr_wr_data != '0) ? cnt_type'(1) : '0;
      end
   end

   assign rsp_valid        = (state_ff == S_RESP);
   assign rsp_status       = st_ff;
   assign rsp_alloc_offset = aoff_ff;
   assign rsp_used_total   = used_ff;
endmodule

// File: hw/rtl/ffra_checker.sv
`timescale 1ns / 1ps
`include "first_fit_range_allocator_assert.svh"
module ffra_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [39:0] rsp_alloc_offset,
   input logic [40:0] rsp_used_total
);
   import ffra_pkg::*;
   // one operation in flight: no new request while a result waits
   `FFRA_ASSERT_IMPL(a_no_overlap, clock, reset, rsp_valid, !req_ready)
   // a result is held while stalled
   `FFRA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_used_total) && $stable(rsp_status))
   // failed operations carry no offset
   `FFRA_ASSERT_IMPL(a_fail_off, clock, reset,
      rsp_valid && rsp_status != ST_OK, rsp_alloc_offset == '0)
   // accepting a request leaves the input not ready in the next cycle
   `FFRA_ASSERT_NEXT(a_acc_busy, clock, reset, req_valid && req_ready, !req_ready)
endmodule

bind first_fit_range_allocator ffra_checker u_ffra_checker (.*);

// File: sim/first_fit_range_allocator_checker.sv
`timescale 1ns / 1ps
module first_fit_range_allocator_checker
   import ffra_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_func,
   input  logic [40:0] req_bytes,
   input  logic [39:0] req_free_offset,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_status,
   input  logic [39:0] rsp_alloc_offset,
   input  logic [40:0] rsp_used_total,
   input  logic        csr_wr_en,
   input  logic [40:0] csr_wr_data,
   output int          errors,
   output int          pending
);
   typedef struct packed {
      status_type st;
      addr_type   off;
      len_type    used;
   } result_type;

   addr_type      free_start [MAX_RANGES];
   len_type       free_len   [MAX_RANGES];
   int            free_cnt;
   len_type       used_bytes;
   result_type    result_q[$];

   function automatic len_type page_round(len_type v);
      logic [63:0] r;
      if (v[11:0] == '0) return v;
      r = {23'b0, v} + 64'd4096 - {52'b0, v[11:0]};
      if (r > {23'b0, LEN_MAX}) return v;
      return r[40:0];
   endfunction

   function automatic len_type clamp_len(logic [63:0] v);
      return (v > {23'b0, LEN_MAX}) ? LEN_MAX : v[40:0];
   endfunction

   function automatic void drop_entry(int i);
      for (int k = i; k + 1 < free_cnt; k++) begin
         free_start[k] = free_start[k+1];
         free_len[k]   = free_len[k+1];
      end
      free_cnt--;
   endfunction

   function automatic void load_pool(len_type p);
      for (int k = 0; k < MAX_RANGES; k++) begin
         free_start[k] = '0;
         free_len[k]   = '0;
      end
      free_len[0] = p;
      free_cnt    = (p != 0) ? 1 : 0;
   endfunction

   function automatic result_type predict_op(logic fn, len_type raw, addr_type foff);
      result_type    res;
      len_type       sz;
      int            pos;
      logic          ml, mr;
      sz       = page_round(raw);
      res.st   = ST_OK;
      res.off  = '0;
      if (fn == FN_ALLOC) begin
         res.st = ST_NOFIT;
         for (int i = 0; i < free_cnt; i++) begin
            if (free_len[i] >= sz) begin
               res.off       = free_start[i];
               free_start[i] = free_start[i] + sz[39:0];
               free_len[i]   = free_len[i] - sz;
               if (free_len[i] == 0) drop_entry(i);
               used_bytes = clamp_len({23'b0, used_bytes} + {23'b0, sz});
               res.st     = ST_OK;
               break;
            end
         end
      end else begin
         if (used_bytes >= sz) begin
            used_bytes = used_bytes - sz;
         end else begin
            used_bytes = '0;
            res.st     = ST_UNDER;
         end
         if (sz != 0) begin
            pos = 0;
            while (pos < free_cnt && free_start[pos] <= foff) pos++;
            ml = pos > 0 &&
                 ({24'b0, free_start[pos-1]} + {23'b0, free_len[pos-1]} == {24'b0, foff});
            mr = pos < free_cnt &&
                 ({24'b0, foff} + {23'b0, sz} == {24'b0, free_start[pos]});
            if (ml && mr) begin
               free_len[pos-1] = clamp_len({23'b0, free_len[pos-1]} + {23'b0, sz}
                                           + {23'b0, free_len[pos]});
               drop_entry(pos);
            end else if (ml) begin
               free_len[pos-1] = clamp_len({23'b0, free_len[pos-1]} + {23'b0, sz});
            end else if (mr) begin
               free_start[pos] = foff;
               free_len[pos]   = clamp_len({23'b0, sz} + {23'b0, free_len[pos]});
            end else if (free_cnt >= MAX_RANGES) begin
               res.st = ST_FULL;
            end else begin
               for (int k = free_cnt; k > pos; k--) begin
                  free_start[k] = free_start[k-1];
                  free_len[k]   = free_len[k-1];
               end
               free_start[pos] = foff;
               free_len[pos]   = sz;
               free_cnt++;
            end
         end
      end
      res.used = used_bytes;
      return res;
   endfunction

   initial begin
      errors = 0;
      pending = 0;
      used_bytes = '0;
      load_pool('0);
   end

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         used_bytes = '0;
         load_pool('0);
         result_q.delete();
      end else begin
         if (csr_wr_en) load_pool(csr_wr_data);
         if (req_valid && req_ready)
            result_q.insert(result_q.size(),
                            predict_op(req_func, req_bytes, req_free_offset));
         if (rsp_valid && rsp_ready) begin
            if (result_q.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected result transaction at %0t", $realtime);
            end else begin
               want = result_q.pop_front();
               if (rsp_status !== want.st || rsp_alloc_offset !== want.off ||
                   rsp_used_total !== want.used) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch at %0t: status %0d/%0d offset %h/%h used %h/%h",
                              $realtime, want.st, rsp_status, want.off,
                              rsp_alloc_offset, want.used, rsp_used_total);
               end
            end
         end
      end
      pending = result_q.size();
   end
endmodule

// File: sim/first_fit_range_allocator_tb.sv
`timescale 1ns / 1ps
module first_fit_range_allocator_tb;
   import ffra_pkg::*;

   localparam int CYCLE_LIMIT = 1200000;
   localparam int PAGE = 4096;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_func = 1'b0;
   logic [40:0] req_bytes = '0;
   logic [39:0] req_free_offset = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [39:0] rsp_alloc_offset;
   logic [40:0] rsp_used_total;
   logic        csr_wr_en = 1'b0;
   logic [40:0] csr_wr_data = '0;
   int          errors, pending;

   int          cycles = 0;
   int          sent = 0;
   int          settings = 0;
   bit          quiet = 0;
   int          status_seen [4];
   bit          op_is_alloc_q[$];
   logic [40:0] op_bytes_q[$];
   logic [39:0] live_off[$];
   logic [40:0] live_len[$];

   first_fit_range_allocator uut (.*);

   first_fit_range_allocator_checker chk (.*);

   initial forever #4 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("first_fit_range_allocator_tb: done, errors");
         $finish;
      end
   end

   always @(posedge clock)
      rsp_ready <= quiet || ($urandom_range(99) >= 18);

   // remember successful allocations so later frees can return them
   always @(posedge clock) begin
      bit          was_alloc;
      logic [40:0] b;
      if (!reset && rsp_valid && rsp_ready && op_is_alloc_q.size() > 0) begin
         was_alloc = op_is_alloc_q.pop_front();
         b = op_bytes_q.pop_front();
         status_seen[rsp_status]++;
         if (was_alloc && rsp_status == ST_OK && b != 0) begin
            live_off.insert(live_off.size(), rsp_alloc_offset);
            live_len.insert(live_len.size(), b);
         end
      end
   end

   task automatic send_op(logic fn, logic [40:0] b, logic [39:0] o);
      bit taken;
      while (!quiet && $urandom_range(99) < 18) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_func        <= fn;
      req_bytes       <= b;
      req_free_offset <= o;
      op_is_alloc_q.insert(op_is_alloc_q.size(), fn == FN_ALLOC);
      op_bytes_q.insert(op_bytes_q.size(), b);
      sent++;
      do begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end while (!taken);
   endtask

   task automatic set_pool(logic [40:0] p);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= p;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      live_off.delete();
      live_len.delete();
      settings++;
   endtask

   task automatic random_op(logic [40:0] pool);
      int          pick;
      int          k;
      logic [40:0] b;
      logic [39:0] o;
      pick = $urandom_range(99);
      if (pick < 45) begin
         b = 41'(($urandom_range(7) + 1) * PAGE);
         if ($urandom_range(3) == 0) b = b - $urandom_range(PAGE - 1);
         if ($urandom_range(30) == 0) b = '0;
         send_op(FN_ALLOC, b, 40'({$urandom, $urandom}));
      end else if (pick < 80 && live_off.size() > 0) begin
         k = $urandom_range(live_off.size() - 1);
         o = live_off[k];
         b = live_len[k];
         live_off.delete(k);
         live_len.delete(k);
         send_op(FN_FREE, b, o);
      end else if (pick < 90) begin
         o = 40'({$urandom, $urandom});
         if (pool > PAGE && !pool[40]) o = (o % pool[39:0]) & ~40'hFFF;
         send_op(FN_FREE, 41'(($urandom_range(3) + 1) * PAGE), o);
      end else begin
         send_op(1'($urandom_range(1)), 41'({$urandom, $urandom}),
                 40'({$urandom, $urandom}));
      end
   endtask

   initial begin
      logic [40:0] pools [5];
      for (int i = 0; i < 4; i++) status_seen[i] = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty pool: allocations fail until frees build the table
      set_pool('0);
      send_op(FN_ALLOC, '0, '0);
      send_op(FN_ALLOC, 41'd4096, '0);
      send_op(FN_FREE, '0, 40'h12345);
      send_op(FN_FREE, 41'd1, '0);
      send_op(FN_ALLOC, '0, '1);
      send_op(FN_ALLOC, 41'd1, '0);
      send_op(FN_FREE, 41'd4096, 40'd4096);

      // full-width pool: rounding limit, saturation, wrap, merge overflow
      set_pool('1);
      send_op(FN_ALLOC, '1, '0);
      send_op(FN_ALLOC, 41'd1, '0);
      send_op(FN_ALLOC, '0, '0);
      send_op(FN_FREE, 41'h100_0000_0000, '0);
      send_op(FN_ALLOC, 41'h100_0000_1000, '0);
      send_op(FN_ALLOC, 41'h0FF_FFFF_E000, '0);
      send_op(FN_FREE, '1, 40'h100);
      send_op(FN_FREE, 41'h100_0000_0000, 40'hFF_FFFF_F000);
      send_op(FN_FREE, 41'd8192, '1);
      send_op(FN_ALLOC, 41'h0AA_AAAA_AAAA, '0);
      send_op(FN_FREE, 41'h155_5555_5555, 40'h55_5555_5555);

      pools[0] = 41'd64 * PAGE;
      pools[1] = 41'h100_0000_0000;
      pools[2] = '1;
      pools[3] = 41'd37 * PAGE + 123;
      pools[4] = 41'({$urandom_range(255), $urandom}) & ~41'hFFF;
      for (int p = 0; p < 5; p++) begin
         set_pool(pools[p]);
         // scattered single-page frees push the table toward full
         if (p == 1)
            for (int i = 0; i < 70; i++)
               send_op(FN_FREE, 41'd4096,
                       40'({$urandom_range(255), $urandom}) & ~40'h1FFF);
         for (int i = 0; i < 160; i++) begin
            quiet = (p == 2 && i >= 40 && i < 140);
            random_op(pools[p]);
         end
         quiet = 0;
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      $display("ran %0d operations over %0d pool sizes", sent, settings);
      $display("results seen: ok %0d, no fit %0d, underflow %0d, table full %0d",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
      if (errors == 0) begin
         $display("first_fit_range_allocator_tb: done, clean");
      end else begin
         $display("first_fit_range_allocator_tb: done, errors");
      end
      $finish;
   end
endmodule

// File: first_fit_range_allocator.f
+incdir+hw/rtl
hw/rtl/ffra_pkg.sv
hw/rtl/ffra_ram.sv
hw/rtl/first_fit_range_allocator.sv
hw/rtl/ffra_checker.sv
sim/first_fit_range_allocator_checker.sv
sim/first_fit_range_allocator_tb.sv
